/* sv/rbm_pkg.sv */
// Shared types, register indexes, blend mode codes and the divide-by-255 helper.
// No dependencies; used by rbm_lane and the top level.
package rbm_pkg;

   typedef logic [7:0] chan_type;

   localparam logic [3:0] REG_MODE    = 4'd0;
   localparam logic [3:0] REG_OPACITY = 4'd1;

   localparam logic [3:0] MODE_NORMAL   = 4'd0;
   localparam logic [3:0] MODE_MULTIPLY = 4'd1;
   localparam logic [3:0] MODE_SCREEN   = 4'd2;
   localparam logic [3:0] MODE_DIFF     = 4'd3;
   localparam logic [3:0] MODE_ADD      = 4'd4;
   localparam logic [3:0] MODE_SUB      = 4'd5;
   localparam logic [3:0] MODE_DARKEN   = 4'd6;
   localparam logic [3:0] MODE_LIGHTEN  = 4'd7;
   localparam logic [3:0] MODE_OVERLAY  = 4'd8;
   localparam logic [3:0] MODE_DODGE    = 4'd9;
   localparam logic [3:0] MODE_BURN     = 4'd10;
   localparam logic [3:0] MODE_HARD     = 4'd11;
   localparam logic [3:0] MODE_SOFT     = 4'd12;

   localparam int unsigned LATENCY = 6;

   // x / 255 for x < 2^17: reciprocal estimate (never high, at most one low)
   // followed by a single remainder correction.
   function automatic logic [9:0] div255(input logic [17:0] x);
      logic [31:0] prod;
      logic [9:0]  est;
      logic [17:0] rem;
      prod = 32'(x) * 32'd16448;
      est  = prod[31:22];
      rem  = x - 18'(est) * 18'd255;
      return (rem >= 18'd255) ? est + 10'd1 : est;
   endfunction

endpackage

/* sv/rbm_lane.sv */
// One colour channel: blend mode, then opacity mix, six register stages.
// Depends on rbm_pkg.
module rbm_lane
   import rbm_pkg::*;
(
   input  logic       clock,
   input  chan_type   a_i,
   input  chan_type   b_i,
   input  logic [3:0] mode_i,
   input  chan_type   op_i,
   output chan_type   r_o
);

   // ---------------- stage 1: products and divider operands
   chan_type    a1_ff, b1_ff, op1_ff;
   logic [3:0]  mode1_ff;
   logic [15:0] ab1_ff, inv1_ff, num1_ff;
   logic [13:0] bb1_ff;
   logic signed [8:0] sa1_ff;
   chan_type    dv1_ff;

   logic        burn_in;
   chan_type    x_in;

   always_comb begin
      burn_in = (mode_i == MODE_BURN);
      x_in    = burn_in ? 8'd255 - b_i : b_i;
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a_i;
      b1_ff    <= b_i;
      op1_ff   <= op_i;
      mode1_ff <= mode_i;
      ab1_ff   <= 16'(a_i) * 16'(b_i);
      inv1_ff  <= 16'(8'd255 - a_i) * 16'(8'd255 - b_i);
      num1_ff  <= {x_in, 8'd0} - 16'(x_in);
      dv1_ff   <= burn_in ? a_i : 8'd255 - a_i;
      bb1_ff   <= 14'(16'(b_i) * 16'(8'd255 - b_i));
      sa1_ff   <= $signed({1'b0, a_i, 1'b0}) - 10'sd255 > 0 ?
                  9'($signed({1'b0, a_i, 1'b0}) - 10'sd255) :
                  9'($signed({1'b0, a_i, 1'b0}) - 10'sd255);
   end

   // ---------------- stage 2: /255 modes, soft product, divide high nibble
   chan_type    b2_ff, op2_ff, rs2_ff;
   logic [3:0]  mode2_ff;
   logic signed [22:0] sp2_ff;
   logic        ovf2_ff;
   chan_type    rem2_ff, dv2_ff;
   logic [3:0]  qh2_ff, nlo2_ff;

   logic [9:0]  mul_q, scr_q, ovl_q, ovh_q;
   chan_type    ov_lo, ov_hi, rs_in;
   logic [8:0]  sum_in;
   logic [8:0]  rw;
   chan_type    rr;
   logic [3:0]  qh_in;

   always_comb begin
      mul_q = div255({2'b0, ab1_ff});
      scr_q = div255({2'b0, inv1_ff});
      ovl_q = div255({1'b0, ab1_ff, 1'b0});
      ovh_q = div255({1'b0, inv1_ff, 1'b0});
      ov_lo = ovl_q[7:0];
      ov_hi = 8'd255 - ovh_q[7:0];
      sum_in = 9'(a1_ff) + 9'(b1_ff);
      case (mode1_ff)
         MODE_MULTIPLY: rs_in = mul_q[7:0];
         MODE_SCREEN:   rs_in = 8'd255 - scr_q[7:0];
         MODE_DIFF:     rs_in = (a1_ff > b1_ff) ? a1_ff - b1_ff : b1_ff - a1_ff;
         MODE_ADD:      rs_in = sum_in[8] ? 8'd255 : sum_in[7:0];
         MODE_SUB:      rs_in = (a1_ff > b1_ff) ? a1_ff - b1_ff : 8'd0;
         MODE_DARKEN:   rs_in = (a1_ff < b1_ff) ? a1_ff : b1_ff;
         MODE_LIGHTEN:  rs_in = (a1_ff > b1_ff) ? a1_ff : b1_ff;
         MODE_OVERLAY:  rs_in = b1_ff[7] ? ov_hi : ov_lo;
         MODE_HARD:     rs_in = a1_ff[7] ? ov_hi : ov_lo;
         default:       rs_in = a1_ff;
      endcase
      // restoring divide, quotient bits 7..4
      rr = num1_ff[15:8];
      for (int i = 7; i >= 4; i--) begin
         rw = {rr, num1_ff[i]};
         if (rw >= 9'(dv1_ff)) begin
            rw = rw - 9'(dv1_ff);
            qh_in[i-4] = 1'b1;
         end else begin
            qh_in[i-4] = 1'b0;
         end
         rr = rw[7:0];
      end
   end

   always_ff @(posedge clock) begin
      b2_ff    <= b1_ff;
      op2_ff   <= op1_ff;
      mode2_ff <= mode1_ff;
      rs2_ff   <= rs_in;
      sp2_ff   <= 23'(sa1_ff) * 23'($signed({1'b0, bb1_ff}));
      ovf2_ff  <= (num1_ff[15:8] >= dv1_ff);   // quotient above 255, or divisor zero
      rem2_ff  <= rr;
      dv2_ff   <= dv1_ff;
      qh2_ff   <= qh_in;
      nlo2_ff  <= num1_ff[3:0];
   end

   // ---------------- stage 3: divide low nibble, soft estimate
   chan_type    b3_ff, op3_ff, r3_ff;
   logic        soft3_ff, neg3_ff;
   logic [21:0] m3_ff;
   logic [6:0]  qs3_ff;

   logic [8:0]  rw3;
   chan_type    rr3;
   logic [3:0]  ql_in;
   chan_type    q_div, r_in;
   logic [22:0] sp_abs;
   logic [32:0] sprod;

   always_comb begin
      rr3 = rem2_ff;
      for (int i = 3; i >= 0; i--) begin
         rw3 = {rr3, nlo2_ff[i]};
         if (rw3 >= 9'(dv2_ff)) begin
            rw3 = rw3 - 9'(dv2_ff);
            ql_in[i] = 1'b1;
         end else begin
            ql_in[i] = 1'b0;
         end
         rr3 = rw3[7:0];
      end
      q_div = {qh2_ff, ql_in};
      case (mode2_ff)
         MODE_DODGE: r_in = ovf2_ff ? 8'd255 : q_div;
         MODE_BURN:  r_in = ovf2_ff ? 8'd0 : 8'd255 - q_div;
         default:    r_in = rs2_ff;
      endcase
      sp_abs = sp2_ff[22] ? 23'(-sp2_ff) : 23'(sp2_ff);
      sprod  = 33'(sp_abs[21:0]) * 33'd1032;
   end

   always_ff @(posedge clock) begin
      b3_ff    <= b2_ff;
      op3_ff   <= op2_ff;
      r3_ff    <= r_in;
      soft3_ff <= (mode2_ff == MODE_SOFT);
      neg3_ff  <= sp2_ff[22];
      m3_ff    <= sp_abs[21:0];
      qs3_ff   <= sprod[32:26];
   end

   // ---------------- stage 4: soft light correction and clamp
   chan_type    b4_ff, op4_ff, r4_ff;

   logic [21:0] srem;
   logic [6:0]  qs;
   logic signed [9:0] sv;
   chan_type    r4_in;

   always_comb begin
      srem = m3_ff - 22'(qs3_ff) * 22'd65025;
      qs   = (srem >= 22'd65025) ? qs3_ff + 7'd1 : qs3_ff;
      sv   = neg3_ff ? $signed({2'b0, b3_ff}) - $signed({3'b0, qs})
                     : $signed({2'b0, b3_ff}) + $signed({3'b0, qs});
      if (!soft3_ff)
         r4_in = r3_ff;
      else if (sv < 0)
         r4_in = 8'd0;
      else if (sv > 10'sd255)
         r4_in = 8'd255;
      else
         r4_in = sv[7:0];
   end

   always_ff @(posedge clock) begin
      b4_ff  <= b3_ff;
      op4_ff <= op3_ff;
      r4_ff  <= r4_in;
   end

   // ---------------- stage 5: opacity products
   logic [15:0] pr5_ff, pb5_ff;

   always_ff @(posedge clock) begin
      pr5_ff <= 16'(op4_ff) * 16'(r4_ff);
      pb5_ff <= 16'(8'd255 - op4_ff) * 16'(b4_ff);
   end

   // ---------------- stage 6: scale and sum
   logic [9:0] sum6;
   chan_type   r6_ff;

   always_comb begin
      sum6 = div255({2'b0, pr5_ff}) + div255({2'b0, pb5_ff});
   end

   always_ff @(posedge clock) begin
      r6_ff <= sum6[7:0];
   end

   assign r_o = r6_ff;

endmodule

/* sv/rgb_blend_modes_with_opacity_top.sv */
// Separable RGB blend modes with layer opacity, three channel lanes in parallel.
// Throughput one pixel per cycle.
// busy is never raised; a pixel may be started every cycle.
// The six-stage lane pipeline (products, divide, soft-light scaling, mix) sets latency.
// Synchronous active-high reset clears the valid pipe, mode to normal, opacity to 255.
// Depends on rbm_pkg and rbm_lane.
module rgb_blend_modes_with_opacity_top
   import rbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_dst_pixel,
   input  logic [31:0] req_src_pixel,
   output logic        rsp_valid,
   output logic [23:0] rsp_out_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [3:0]         mode_ff;
   chan_type           opacity_ff;
   logic [LATENCY-1:0] vld_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         opacity_ff <= 8'd255;
         vld_ff     <= '0;
      end else begin
         if (csr_valid && csr_index == REG_MODE)
            mode_ff <= csr_data[3:0];
         if (csr_valid && csr_index == REG_OPACITY)
            opacity_ff <= csr_data;
         vld_ff <= {vld_ff[LATENCY-2:0], start};
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      rbm_lane u_lane (
         .clock  (clock),
         .a_i    (req_src_pixel[8*c +: 8]),
         .b_i    (req_dst_pixel[8*c +: 8]),
         .mode_i (mode_ff),
         .op_i   (opacity_ff),
         .r_o    (rsp_out_pixel[8*c +: 8])
      );
   end

   assign rsp_valid = vld_ff[LATENCY-1];

`ifndef SYNTH
   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result beat without a started pixel");

   a_opacity_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == REG_OPACITY |=> opacity_ff == $past(csr_data))
      else $error("opacity register missed a write");
`endif

endmodule
